/* rtl/core/ocw_pkg.sv */
// Shared types and codes for the offboard command watchdog.
package ocw_pkg;

  localparam int TimeW    = 63;
  localparam int TimeoutW = 32;
  localparam int LimitW   = 16;
  localparam int CountW   = 17;
  localparam int ModeW    = 3;
  localparam int CodeW    = 4;
  localparam int RegIdxW  = 2;

  // Event codes
  localparam logic [1:0] FUNC_TICK     = 2'd0;
  localparam logic [1:0] FUNC_START    = 2'd1;
  localparam logic [1:0] FUNC_SET_MODE = 2'd2;
  localparam logic [1:0] FUNC_SETPOINT = 2'd3;

  // Control modes
  localparam logic [ModeW-1:0] MODE_POS   = 3'd0;
  localparam logic [ModeW-1:0] MODE_VEL   = 3'd1;
  localparam logic [ModeW-1:0] MODE_ACCEL = 3'd2;
  localparam logic [ModeW-1:0] MODE_ATT   = 3'd3;
  localparam logic [ModeW-1:0] MODE_RATE  = 3'd4;

  // Reported state codes
  localparam logic [CodeW-1:0] CODE_INIT     = 4'd0;
  localparam logic [CodeW-1:0] CODE_READY    = 4'd1;
  localparam logic [CodeW-1:0] CODE_POS      = 4'd2;
  localparam logic [CodeW-1:0] CODE_VEL      = 4'd3;
  localparam logic [CodeW-1:0] CODE_ACCEL    = 4'd4;
  localparam logic [CodeW-1:0] CODE_ATT      = 4'd5;
  localparam logic [CodeW-1:0] CODE_RATE     = 4'd6;
  localparam logic [CodeW-1:0] CODE_TIMEOUT  = 4'd7;
  localparam logic [CodeW-1:0] CODE_HOLD     = 4'd8;
  localparam logic [CodeW-1:0] CODE_FAILSAFE = 4'd9;
  localparam logic [CodeW-1:0] CODE_LAND     = 4'd10;

  localparam logic [2:0] HB_NONE = 3'd0;

  localparam logic [1:0] CMD_NONE   = 2'd0;
  localparam logic [1:0] CMD_LOITER = 2'd1;
  localparam logic [1:0] CMD_LAND   = 2'd2;

  // Register indexes
  localparam logic [RegIdxW-1:0] REG_MOTION_TIMEOUT   = 2'd0;
  localparam logic [RegIdxW-1:0] REG_ATTITUDE_TIMEOUT = 2'd1;
  localparam logic [RegIdxW-1:0] REG_HOLD_LIMIT       = 2'd2;

  localparam logic [TimeoutW-1:0] MOTION_TIMEOUT_RST   = 32'd500000000;
  localparam logic [TimeoutW-1:0] ATTITUDE_TIMEOUT_RST = 32'd100000000;
  localparam logic [LimitW-1:0]   HOLD_LIMIT_RST       = 16'd100;

  typedef struct packed {
    logic [1:0]       func;
    logic [ModeW-1:0] mode_req;
    logic [TimeW-1:0] now_ns;
  } event_t;

  typedef struct packed {
    logic             accepted;
    logic [CodeW-1:0] state_code;
    logic [2:0]       heartbeat;
    logic [1:0]       vehicle_cmd;
  } result_t;

  typedef struct packed {
    logic [RegIdxW-1:0]  index;
    logic [TimeoutW-1:0] value;
  } cfg_write_t;

endpackage

/* rtl/core/ocw_event_if.sv */
// Event channel: valid/ready with one event item.
interface ocw_event_if;
  logic            valid;
  logic            ready;
  ocw_pkg::event_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/ocw_result_if.sv */
// Result channel: valid/ready with one result item.
interface ocw_result_if;
  logic             valid;
  logic             ready;
  ocw_pkg::result_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/ocw_cfg_if.sv */
// Configuration write channel: valid/ready with register index and data.
interface ocw_cfg_if;
  logic                valid;
  logic                ready;
  ocw_pkg::cfg_write_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/offboard_command_watchdog_fsm.sv */
// Offboard command watchdog: one event in, one result out per item, one item per
// clock cycle. Each accepted event (tick, start, set mode, setpoint) is decided in
// the cycle it is taken and its result lands in the output register on the next
// edge; the block takes a new item every cycle as long as the output register is
// empty or is being drained, so the output side sets the rate. The age check is
// one 64-bit subtract and compare against the timeout of the current (or, in
// hold, the recorded) mode. Configuration writes are taken every cycle and should
// only be issued while no result is pending.
module offboard_command_watchdog_fsm (
  input  logic                clk,
  input  logic                rst,
  ocw_event_if.sink           events,
  ocw_result_if.source        results,
  ocw_cfg_if.sink             cfg
);

  typedef enum logic [10:0] {
    ST_INIT     = 11'b000_0000_0001,
    ST_READY    = 11'b000_0000_0010,
    ST_POS      = 11'b000_0000_0100,
    ST_VEL      = 11'b000_0000_1000,
    ST_ACCEL    = 11'b000_0001_0000,
    ST_ATT      = 11'b000_0010_0000,
    ST_RATE     = 11'b000_0100_0000,
    ST_TIMEOUT  = 11'b000_1000_0000,
    ST_HOLD     = 11'b001_0000_0000,
    ST_FAILSAFE = 11'b010_0000_0000,
    ST_LAND     = 11'b100_0000_0000
  } state_t;

  state_t                               state, state_next;
  logic [ocw_pkg::ModeW-1:0]            saved_mode, saved_mode_next;
  logic [ocw_pkg::TimeW-1:0]            last_cmd_time, last_cmd_time_next;
  logic [ocw_pkg::CountW-1:0]           hold_count, hold_count_next;
  logic [ocw_pkg::TimeoutW-1:0]         motion_timeout_ns, attitude_timeout_ns;
  logic [ocw_pkg::LimitW-1:0]           hold_limit;
  logic                                 res_valid;
  ocw_pkg::result_t                     res, res_data;

  logic                                 ev_acc;
  logic [ocw_pkg::ModeW-1:0]            cur_mode, check_mode;
  logic [ocw_pkg::TimeoutW-1:0]         timeout_sel;
  logic signed [ocw_pkg::TimeW:0]       elapsed, timeout_ext;
  logic                                 stale, fresh;

  function automatic state_t mode_state(input logic [ocw_pkg::ModeW-1:0] m);
    state_t s;
    case (m)
      ocw_pkg::MODE_POS:   s = ST_POS;
      ocw_pkg::MODE_VEL:   s = ST_VEL;
      ocw_pkg::MODE_ACCEL: s = ST_ACCEL;
      ocw_pkg::MODE_ATT:   s = ST_ATT;
      ocw_pkg::MODE_RATE:  s = ST_RATE;
      default:             s = ST_POS;
    endcase
    return s;
  endfunction

  function automatic logic [ocw_pkg::CodeW-1:0] state_code(input state_t s);
    logic [ocw_pkg::CodeW-1:0] c;
    case (s)
      ST_INIT:     c = ocw_pkg::CODE_INIT;
      ST_READY:    c = ocw_pkg::CODE_READY;
      ST_POS:      c = ocw_pkg::CODE_POS;
      ST_VEL:      c = ocw_pkg::CODE_VEL;
      ST_ACCEL:    c = ocw_pkg::CODE_ACCEL;
      ST_ATT:      c = ocw_pkg::CODE_ATT;
      ST_RATE:     c = ocw_pkg::CODE_RATE;
      ST_TIMEOUT:  c = ocw_pkg::CODE_TIMEOUT;
      ST_HOLD:     c = ocw_pkg::CODE_HOLD;
      ST_FAILSAFE: c = ocw_pkg::CODE_FAILSAFE;
      ST_LAND:     c = ocw_pkg::CODE_LAND;
      default:     c = ocw_pkg::CODE_INIT;
    endcase
    return c;
  endfunction

  assign events.ready  = !res_valid || results.ready;
  assign ev_acc        = events.valid && events.ready;
  assign cfg.ready     = 1'b1;
  assign results.valid = res_valid;
  assign results.data  = res_data;

  always_comb begin
    case (state)
      ST_VEL:   cur_mode = ocw_pkg::MODE_VEL;
      ST_ACCEL: cur_mode = ocw_pkg::MODE_ACCEL;
      ST_ATT:   cur_mode = ocw_pkg::MODE_ATT;
      ST_RATE:  cur_mode = ocw_pkg::MODE_RATE;
      default:  cur_mode = ocw_pkg::MODE_POS;
    endcase
  end

  // In hold the recorded mode sets the timeout, otherwise the active mode.
  assign check_mode  = (state == ST_HOLD) ? saved_mode : cur_mode;
  assign timeout_sel = (check_mode <= ocw_pkg::MODE_ACCEL) ? motion_timeout_ns
                                                           : attitude_timeout_ns;
  assign elapsed     = $signed({1'b0, events.data.now_ns}) - $signed({1'b0, last_cmd_time});
  assign timeout_ext = $signed({{(ocw_pkg::TimeW + 1 - ocw_pkg::TimeoutW){1'b0}}, timeout_sel});
  assign stale       = elapsed > timeout_ext;
  assign fresh       = elapsed < timeout_ext;

  always_comb begin
    state_next         = state;
    saved_mode_next    = saved_mode;
    last_cmd_time_next = last_cmd_time;
    hold_count_next    = hold_count;
    res.accepted       = 1'b0;
    res.heartbeat      = ocw_pkg::HB_NONE;
    res.vehicle_cmd    = ocw_pkg::CMD_NONE;
    case (events.data.func)
      ocw_pkg::FUNC_START: begin
        if (state == ST_INIT) begin
          state_next   = ST_READY;
          res.accepted = 1'b1;
        end
      end
      ocw_pkg::FUNC_SET_MODE: begin
        if (state != ST_INIT && events.data.mode_req <= ocw_pkg::MODE_RATE) begin
          state_next         = mode_state(events.data.mode_req);
          last_cmd_time_next = events.data.now_ns;
          res.accepted       = 1'b1;
        end
      end
      ocw_pkg::FUNC_SETPOINT: begin
        if (state != ST_INIT) begin
          last_cmd_time_next = events.data.now_ns;
          res.accepted       = 1'b1;
        end
      end
      ocw_pkg::FUNC_TICK: begin
        case (state)
          ST_POS, ST_VEL, ST_ACCEL, ST_ATT, ST_RATE: begin
            if (stale) begin
              saved_mode_next = cur_mode;
              state_next      = ST_TIMEOUT;
            end else begin
              res.heartbeat = 3'(cur_mode + 3'd1);
            end
          end
          ST_TIMEOUT: begin
            res.vehicle_cmd = ocw_pkg::CMD_LOITER;
            hold_count_next = '0;
            state_next      = ST_HOLD;
          end
          ST_HOLD: begin
            // count saturates; the limit is checked against the old count
            if (hold_count != '1) begin
              hold_count_next = hold_count + 1'b1;
            end
            if (hold_count > ocw_pkg::CountW'(hold_limit)) begin
              state_next = ST_FAILSAFE;
            end else if (saved_mode <= ocw_pkg::MODE_RATE && fresh) begin
              state_next = mode_state(saved_mode);
            end
          end
          ST_FAILSAFE: begin
            res.vehicle_cmd = ocw_pkg::CMD_LAND;
            state_next      = ST_LAND;
          end
          default: begin
          end
        endcase
      end
      default: begin
      end
    endcase
    res.state_code = state_code(state_next);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state               <= ST_INIT;
      saved_mode          <= ocw_pkg::MODE_POS;
      last_cmd_time       <= '0;
      hold_count          <= '0;
      motion_timeout_ns   <= ocw_pkg::MOTION_TIMEOUT_RST;
      attitude_timeout_ns <= ocw_pkg::ATTITUDE_TIMEOUT_RST;
      hold_limit          <= ocw_pkg::HOLD_LIMIT_RST;
      res_valid           <= 1'b0;
    end else begin
      if (ev_acc) begin
        state         <= state_next;
        saved_mode    <= saved_mode_next;
        last_cmd_time <= last_cmd_time_next;
        hold_count    <= hold_count_next;
        res_valid     <= 1'b1;
      end else if (results.ready) begin
        res_valid <= 1'b0;
      end
      if (cfg.valid) begin
        case (cfg.data.index)
          ocw_pkg::REG_MOTION_TIMEOUT:   motion_timeout_ns   <= cfg.data.value;
          ocw_pkg::REG_ATTITUDE_TIMEOUT: attitude_timeout_ns <= cfg.data.value;
          ocw_pkg::REG_HOLD_LIMIT:       hold_limit <= cfg.data.value[ocw_pkg::LimitW-1:0];
          default: begin
          end
        endcase
      end
    end
  end

  // Hold the result until taken
  always_ff @(posedge clk) begin
    if (ev_acc) begin
      res_data <= res;
    end
  end

  a_tick_not_accepted: assert property (@(posedge clk) disable iff (rst)
    ev_acc && events.data.func == ocw_pkg::FUNC_TICK |=> !results.data.accepted)
    else $error("tick reported as accepted");

  a_timeout_enters_hold: assert property (@(posedge clk) disable iff (rst)
    ev_acc && events.data.func == ocw_pkg::FUNC_TICK && state == ST_TIMEOUT
    |=> state == ST_HOLD && hold_count == '0
        && results.data.vehicle_cmd == ocw_pkg::CMD_LOITER)
    else $error("timeout tick did not enter hold with loiter");

  a_heartbeat_in_mode: assert property (@(posedge clk) disable iff (rst)
    results.valid && results.data.heartbeat != ocw_pkg::HB_NONE
    |-> results.data.vehicle_cmd == ocw_pkg::CMD_NONE
        && results.data.state_code >= ocw_pkg::CODE_POS
        && results.data.state_code <= ocw_pkg::CODE_RATE)
    else $error("heartbeat outside an active mode");

  a_state_held_when_idle: assert property (@(posedge clk) disable iff (rst)
    !ev_acc |=> $stable(state) && $stable(last_cmd_time) && $stable(hold_count))
    else $error("state moved without an accepted item");

  a_reset_clears_output: assert property (@(posedge clk)
    rst |=> !results.valid)
    else $error("result valid after reset");

endmodule
